FILE: rtl/core/swa_pkg.sv
// Shared types and fixed widths for the sliding window average core.
// No dependencies; every module of the core imports this package.
`default_nettype none
package swa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TOTAL_W  = 24;
	localparam int LEN_W    = 8;
	localparam int REM_W    = LEN_W + 1;
	localparam int DIV_CNT_W = $clog2(TOTAL_W);

	localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/swa_window.sv
// Sample history as a shift line that can also rotate through its head tap.
// Depends on swa_pkg for the sample width.
`default_nettype none
module swa_window
	import swa_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        shift_en,
	input  wire                        rotate_en,
	input  wire logic [SAMPLE_W-1:0]   sample_in,
	output logic      [SAMPLE_W-1:0]   head
);

	logic [SAMPLE_W-1:0] win_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift_en) begin
			// newest at the head, drop the oldest
			win_q[0] <= sample_in;
			for (int k = 1; k < DEPTH; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end else if (rotate_en) begin
			// advance towards the head, wrap the head round to the tail
			win_q[DEPTH-1] <= win_q[0];
			for (int k = 0; k < DEPTH - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
		end
	end

	assign head = win_q[0];

endmodule
`default_nettype wire

FILE: rtl/core/swa_div.sv
// Bit-serial restoring divider: signed total by unsigned length, one quotient bit a cycle.
// Depends on swa_pkg for widths and the control and status structs.
`default_nettype none
module swa_div
	import swa_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire div_ctrl_t            ctrl,
	input  wire logic [TOTAL_W-1:0]   total,
	input  wire logic [LEN_W-1:0]     divisor,
	output div_stat_t                 stat,
	output logic      [SAMPLE_W-1:0]  quotient
);

	logic [TOTAL_W-1:0]   dvd_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;

	logic [REM_W-1:0]     trial;
	logic                 fits;
	logic [SAMPLE_W-1:0]  mag;

	// remainder stays below the divisor, so it always fits in LEN_W bits
	assign trial = {rem_q, dvd_q[TOTAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(TOTAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			neg_q <= total[TOTAL_W-1];
			dvd_q <= total[TOTAL_W-1] ? (~total + 1'b1) : total;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? LEN_W'(trial - {1'b0, dsr_q}) : trial[LEN_W-1:0];
			dvd_q <= {dvd_q[TOTAL_W-2:0], fits};
		end
	end

	assign mag         = dvd_q[SAMPLE_W-1:0];
	assign quotient    = neg_q ? (~mag + 1'b1) : mag;
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_average_core.sv
// Top level of the sliding window average: handshakes, sequencer and accumulator.
// Depends on swa_pkg, swa_window and swa_div.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   input    | in_valid / in_ready  | sample        (16-bit signed)
//   output   | out_valid / out_ready| average       (16-bit signed)
//   config   | cfg_valid / cfg_ready| window_length (8-bit unsigned)
//
// One word goes from acceptance to a loaded result in three steps: one full
// rotation of the window through the accumulator, the bit-serial divide of the
// total, then the hand-over state that loads the output register.
// Reset clears the window, the total and the length register (16); no sweep.
// A result waiting on out_ready does not block the next input word; the
// sequencer only holds in its hand-over state if the output register is full.
`default_nettype none
module sliding_window_average_core
	import swa_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic      [SAMPLE_W-1:0]  average,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [LEN_W-1:0]     window_length
);

	localparam int CNT_W = $clog2(WINDOW_DEPTH);

	state_t              state_q, state_d;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    n_eff;
	logic [CNT_W-1:0]    cnt_q;
	logic [TOTAL_W-1:0]  acc_q;
	logic [TOTAL_W-1:0]  acc_d;
	logic [TOTAL_W-1:0]  head_ext;
	logic [SAMPLE_W-1:0] head;
	logic [SAMPLE_W-1:0] avg_q;
	logic                out_valid_q;
	logic                last_tap;
	logic                in_take;
	logic                rotate_en;
	logic                load_out;
	div_ctrl_t           div_ctrl;
	div_stat_t           div_stat;
	logic [SAMPLE_W-1:0] quotient;

	// Length register; writes must only arrive while idle (the block does not enforce this), so always take them
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= window_length;
		end
	end

	// Clamp the length: zero counts as one, anything past the depth as the depth
	always_comb begin
		if (len_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (len_q > LEN_W'(WINDOW_DEPTH)) begin
			n_eff = LEN_W'(WINDOW_DEPTH);
		end else begin
			n_eff = len_q;
		end
	end

	swa_window #(
		.DEPTH     (WINDOW_DEPTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (in_take),
		.rotate_en (rotate_en),
		.sample_in (sample),
		.head      (head)
	);

	// Sum the newest n_eff taps as they pass the head during the rotation
	assign head_ext = {{(TOTAL_W - SAMPLE_W){head[SAMPLE_W-1]}}, head};
	assign acc_d    = (LEN_W'(cnt_q) < n_eff) ? (acc_q + head_ext) : acc_q;
	assign last_tap = cnt_q == CNT_W'(WINDOW_DEPTH - 1);

	swa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.total    (acc_d),
		.divisor  (n_eff),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (last_tap) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_ready       = 1'b0;
		rotate_en      = 1'b0;
		div_ctrl.start = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SUM: begin
				rotate_en      = 1'b1;
				div_ctrl.start = last_tap;
			end
			ST_WRITE: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				cnt_q <= '0;
				acc_q <= '0;
			end else if (rotate_en) begin
				cnt_q <= cnt_q + 1'b1;
				acc_q <= acc_d;
			end
			// hold the word until taken, refill straight behind it
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q <= quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = avg_q;

`ifndef SYNTHESIS
	a_take_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SUM)
		else $error("accepted word did not start the window sum");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("input ready while the divider is busy");

	a_load_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire
